@@ rtl/core/psmc_pkg.sv @@
// Shared constants for the point set mean and covariance block.
// Default parameter values and the fixed widths of the result fields.
// No dependencies.
package psmc_pkg;

    // Default capacity of the point store and default coordinate width.
    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 16;

    // Fixed widths of the result fields.
    localparam int MEAN_OUT_W = 24;
    localparam int VAR_OUT_W  = 49;
    localparam int COV_OUT_W  = 50;
    localparam int USED_OUT_W = 11;

    // Width of the wrapping arithmetic that the results are taken from.
    localparam int WRAP_W = 64;

endpackage

@@ rtl/core/psmc_div.sv @@
// Iterative signed divider for the point set mean and covariance block.
// Divides a two's complement value by an unsigned count, rounding toward zero,
// one quotient bit per cycle. No package dependencies.
module psmc_div #(
    parameter int DIV_W = 61,
    parameter int DVS_W = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DIV_W-1:0] i_dividend,
    input  logic        [DVS_W-1:0] i_divisor,
    output logic                    o_done,
    output logic signed [DIV_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIN
    } t_div_state;

    t_div_state        r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic              r_neg;

    logic [DIV_W-1:0]  mag;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;

    // Magnitude of the dividend; the most negative value maps onto itself,
    // which is still the right unsigned magnitude.
    assign mag   = i_dividend[DIV_W-1] ? (~i_dividend + 1'b1) : i_dividend;

    // The quotient register shifts dividend bits out at the top while the
    // quotient bits enter at the bottom.
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_quo   <= mag;
                        r_rem   <= '0;
                        r_dvs   <= i_divisor;
                        r_neg   <= i_dividend[DIV_W-1];
                        r_cnt   <= CNT_W'(DIV_W);
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], fits};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= D_FIN;
                    end
                end
                D_FIN: begin
                    o_quotient <= r_neg ? (~r_quo + 1'b1) : r_quo;
                    o_done     <= 1'b1;
                    r_state    <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/point_set_mean_covariance.sv @@
// Top level of the point set mean and covariance block.
// Uses psmc_pkg for field widths and defaults, and psmc_div for all divisions.
// Holds the point store memory, the load logic and the second-pass datapath.
//
//  Channel   | Direction | Transfer at clock edge when   | Fields
//  ----------+-----------+-------------------------------+-----------------------------------
//  point in  | input     | start high and busy low       | i_coord_x/y/z, i_last_point
//  result    | output    | o_valid high (one cycle only) | o_mean_*, o_cov_*, o_points_used,
//            |           |                               | o_overflowed
//
// While a set is being loaded the block takes one point transfer every cycle; each point that
// finds room is written into the point store and added into the axis sums in that same cycle.
// A point marked last raises busy while the serial divider, working at the accumulator width
// (61 bits at the defaults), forms the three means, the store is read once for the second
// pass at one point per cycle, and the divider then forms the six covariance entries.
// The result appears for exactly one cycle with o_valid high; the receiver cannot stall it.
// In that same cycle busy is low again and the cleared block already takes the next set.
// Reset is synchronous and active low; it clears the count, sums, drop flag and all control
// state. The point store needs no clearing, since only entries written for the current set
// are ever read.
module point_set_mean_covariance #(
    parameter int MAX_POINTS = psmc_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = psmc_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [COORD_BITS-1:0]          i_coord_x,
    input  logic signed [COORD_BITS-1:0]          i_coord_y,
    input  logic signed [COORD_BITS-1:0]          i_coord_z,
    input  logic                                  i_last_point,
    output logic                                  o_valid,
    output logic signed [psmc_pkg::MEAN_OUT_W-1:0] o_mean_x,
    output logic signed [psmc_pkg::MEAN_OUT_W-1:0] o_mean_y,
    output logic signed [psmc_pkg::MEAN_OUT_W-1:0] o_mean_z,
    output logic        [psmc_pkg::VAR_OUT_W-1:0]  o_cov_xx,
    output logic signed [psmc_pkg::COV_OUT_W-1:0]  o_cov_xy,
    output logic signed [psmc_pkg::COV_OUT_W-1:0]  o_cov_xz,
    output logic        [psmc_pkg::VAR_OUT_W-1:0]  o_cov_yy,
    output logic signed [psmc_pkg::COV_OUT_W-1:0]  o_cov_yz,
    output logic        [psmc_pkg::VAR_OUT_W-1:0]  o_cov_zz,
    output logic        [psmc_pkg::USED_OUT_W-1:0] o_points_used,
    output logic                                  o_overflowed
);

    import psmc_pkg::*;

    // Count of stored points, wide enough to hold the capacity itself.
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = $clog2(MAX_POINTS);
    // A sum over a full store cannot overflow this width.
    localparam int SUM_W  = COORD_BITS + CNT_W;
    // The mean lies within the range of a coordinate scaled by 256.
    localparam int MEAN_W = COORD_BITS + 8;
    // A scaled coordinate minus a mean needs one bit more.
    localparam int DEV_W  = COORD_BITS + 9;
    localparam int PROD_W = 2 * DEV_W;
    // Accumulators hold the exact sum, or wrap like the 64-bit arithmetic they follow.
    localparam int ACC_W  = (PROD_W + CNT_W > WRAP_W) ? WRAP_W : (PROD_W + CNT_W);
    localparam int PT_W   = 3 * COORD_BITS;
    localparam int NUM_COV = 6;

    localparam logic [2:0] IDX_LAST_MEAN = 3'd2;
    localparam logic [2:0] IDX_LAST_COV  = 3'd5;

    typedef enum logic [1:0] {
        S_LOAD,
        S_MEAN,
        S_PASS,
        S_COV
    } t_state;

    // Control state.
    t_state                     r_state;
    logic [CNT_W-1:0]           r_count;
    logic                       r_drop;
    logic [2:0]                 r_idx;
    logic                       r_div_go;
    logic [CNT_W-1:0]           r_issue;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic                       r_valid;

    // Datapath state.
    logic signed [SUM_W-1:0]    r_sum [3];
    logic signed [SUM_W-1:0]    n_sum [3];
    logic signed [MEAN_W-1:0]   r_mean [3];
    logic [PT_W-1:0]            r_rd_data;
    logic signed [DEV_W-1:0]    r_dev [3];
    logic signed [ACC_W-1:0]    r_prod [NUM_COV];
    logic signed [ACC_W-1:0]    r_acc [NUM_COV];
    logic [COV_OUT_W-1:0]       r_cov [NUM_COV];
    logic [USED_OUT_W-1:0]      r_used;
    logic                       r_ovf;

    // Point store: one write port for loading, one registered read port for the pass.
    logic [PT_W-1:0]            mem_store [MAX_POINTS];

    logic                       accept;
    logic                       room;
    logic                       rd_en;
    logic                       pass_start;
    logic                       pass_end;
    logic signed [COORD_BITS-1:0] rd_coord [3];
    logic signed [COORD_BITS-1:0] in_coord [3];
    logic signed [PROD_W-1:0]   prod [NUM_COV];
    logic signed [ACC_W-1:0]    div_dividend;
    logic                       div_done;
    logic signed [ACC_W-1:0]    div_quotient;
    logic signed [WRAP_W-1:0]   quo_ext;
    logic signed [WRAP_W-1:0]   mean_ext [3];
    logic [WRAP_W-1:0]          count_ext;

    assign busy    = (r_state != S_LOAD);
    assign accept  = start && !busy;
    assign room    = (r_count < CNT_W'(MAX_POINTS));
    assign o_valid = r_valid;

    assign in_coord[0] = i_coord_x;
    assign in_coord[1] = i_coord_y;
    assign in_coord[2] = i_coord_z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_sum[a] = r_sum[a] + SUM_W'(in_coord[a]);
        end
    end

    // Second pass: issue one read per cycle until every stored point is out,
    // then wait for the three pipeline stages behind the read to drain.
    assign rd_en      = (r_state == S_PASS) && (r_issue < r_count);
    assign pass_start = (r_state == S_MEAN) && div_done && (r_idx == IDX_LAST_MEAN);
    assign pass_end   = (r_state == S_PASS) && !rd_en && !r_v1 && !r_v2 && !r_v3;

    // The divider input is taken from the scaled axis sum while the means are
    // formed, and from the accumulators for the covariance entries.
    always_comb begin
        case (r_state)
            S_MEAN:  div_dividend = ACC_W'(r_sum[r_idx[1:0]]) <<< 8;
            S_COV:   div_dividend = r_acc[r_idx];
            default: div_dividend = '0;
        endcase
    end

    assign quo_ext   = WRAP_W'(div_quotient);
    assign count_ext = WRAP_W'(r_count);

    psmc_div #(
        .DIV_W (ACC_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (div_dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Sequencer: loading, the three means, the second pass, the six entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_idx    <= '0;
            r_div_go <= 1'b0;
            r_issue  <= '0;
            r_valid  <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            r_div_go <= 1'b0;
            r_valid  <= 1'b0;
            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        // A point that finds the store full is dropped and flagged,
                        // also when it is the last one of the set.
                        if (room) begin
                            r_count <= r_count + 1'b1;
                            for (int a = 0; a < 3; a++) begin
                                r_sum[a] <= n_sum[a];
                            end
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_last_point) begin
                            r_idx    <= '0;
                            r_div_go <= 1'b1;
                            r_state  <= S_MEAN;
                        end
                    end
                end
                S_MEAN: begin
                    if (div_done) begin
                        r_mean[r_idx[1:0]] <= div_quotient[MEAN_W-1:0];
                        if (r_idx == IDX_LAST_MEAN) begin
                            r_issue <= '0;
                            r_state <= S_PASS;
                        end else begin
                            r_idx    <= r_idx + 1'b1;
                            r_div_go <= 1'b1;
                        end
                    end
                end
                S_PASS: begin
                    if (rd_en) begin
                        r_issue <= r_issue + 1'b1;
                    end
                    if (pass_end) begin
                        r_idx    <= '0;
                        r_div_go <= 1'b1;
                        r_state  <= S_COV;
                    end
                end
                S_COV: begin
                    if (div_done) begin
                        r_cov[r_idx] <= quo_ext[COV_OUT_W-1:0];
                        if (r_idx == IDX_LAST_COV) begin
                            // Present the result and clear the set in the same cycle.
                            r_valid <= 1'b1;
                            r_used  <= count_ext[USED_OUT_W-1:0];
                            r_ovf   <= r_drop;
                            r_count <= '0;
                            r_drop  <= 1'b0;
                            for (int a = 0; a < 3; a++) begin
                                r_sum[a] <= '0;
                            end
                            r_state <= S_LOAD;
                        end else begin
                            r_idx    <= r_idx + 1'b1;
                            r_div_go <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // Point store. Writes happen only while loading and reads only during the
    // pass, so the two ports never touch the same entry in one cycle.
    always_ff @(posedge i_clk) begin
        if (accept && room) begin
            mem_store[r_count[ADDR_W-1:0]] <= {i_coord_z, i_coord_y, i_coord_x};
        end
        if (rd_en) begin
            r_rd_data <= mem_store[r_issue[ADDR_W-1:0]];
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rd_coord[a] = signed'(r_rd_data[a*COORD_BITS +: COORD_BITS]);
        end
    end

    // Six products of deviations: xx, xy, xz, yy, yz, zz.
    assign prod[0] = r_dev[0] * r_dev[0];
    assign prod[1] = r_dev[0] * r_dev[1];
    assign prod[2] = r_dev[0] * r_dev[2];
    assign prod[3] = r_dev[1] * r_dev[1];
    assign prod[4] = r_dev[1] * r_dev[2];
    assign prod[5] = r_dev[2] * r_dev[2];

    // Pass pipeline: read data, deviations, products, accumulation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (r_v1) begin
            for (int a = 0; a < 3; a++) begin
                r_dev[a] <= (DEV_W'(rd_coord[a]) <<< 8) - DEV_W'(r_mean[a]);
            end
        end
        if (r_v2) begin
            for (int k = 0; k < NUM_COV; k++) begin
                r_prod[k] <= ACC_W'(prod[k]);
            end
        end
        if (pass_start) begin
            for (int k = 0; k < NUM_COV; k++) begin
                r_acc[k] <= '0;
            end
        end else if (r_v3) begin
            for (int k = 0; k < NUM_COV; k++) begin
                r_acc[k] <= r_acc[k] + r_prod[k];
            end
        end
    end

    // Result ports. The means are extended or cut to the field width.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mean_ext[a] = WRAP_W'(r_mean[a]);
        end
    end

    assign o_mean_x      = mean_ext[0][MEAN_OUT_W-1:0];
    assign o_mean_y      = mean_ext[1][MEAN_OUT_W-1:0];
    assign o_mean_z      = mean_ext[2][MEAN_OUT_W-1:0];
    assign o_cov_xx      = r_cov[0][VAR_OUT_W-1:0];
    assign o_cov_xy      = r_cov[1];
    assign o_cov_xz      = r_cov[2];
    assign o_cov_yy      = r_cov[3][VAR_OUT_W-1:0];
    assign o_cov_yz      = r_cov[4];
    assign o_cov_zz      = r_cov[5][VAR_OUT_W-1:0];
    assign o_points_used = r_used;
    assign o_overflowed  = r_ovf;

    // A result is a single-cycle strobe.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    // A result only ends a computation, never a load.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> $past(busy))
        else $error("result without a preceding computation");

    // The store never holds more points than its capacity.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

    // The pass never reads past the points of the current set.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS) |-> (r_issue <= r_count))
        else $error("pass read beyond stored points");

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_MEAN || r_state == S_COV))
        else $error("division finished outside a division phase");

endmodule
